// ===== hdl/tbh_pkg.sv =====
`default_nettype none

package tbh_pkg;

  // Field and register widths.
  localparam int unsigned SPEED_W = 13;
  localparam int unsigned ERR_W   = 14;
  localparam int unsigned DRIVE_W = 17;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned POWER_W = 14;
  localparam int unsigned CMD_W   = 14;
  localparam int unsigned INDEX_W = 2;
  localparam int unsigned CNT_W   = 5;

  // Serial multiplier lengths: one multiplier bit per cycle.
  localparam int unsigned GAIN_MUL_CYCLES  = ERR_W - 1;
  localparam int unsigned POWER_MUL_CYCLES = DRIVE_W;

  // Product widths of the two serial multipliers.
  localparam int unsigned PROD1_W = GAIN_W + ERR_W - 1;
  localparam int unsigned PROD2_W = POWER_W + DRIVE_W;

  // Fixed-point constants.
  localparam logic [DRIVE_W-1:0] DRIVE_ONE = DRIVE_W'(65536);
  localparam logic [CMD_W-1:0]   CMD_LIMIT = CMD_W'(12000);

  // Register reset values.
  localparam logic [GAIN_W-1:0]  LOOP_GAIN_RESET = GAIN_W'(20133);
  localparam logic [POWER_W-1:0] MAX_POWER_RESET = POWER_W'(12000);

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] CFG_LOOP_GAIN = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] CFG_MAX_POWER = INDEX_W'(1);

  // Input function codes.
  localparam logic FUNC_SAMPLE   = 1'b0;
  localparam logic FUNC_SETPOINT = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_GAIN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_POWER  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/take_back_half_velocity_controller.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   func, measured_velocity, new_target, drive_estimate
// out       output     out_valid / out_ready motor_command, drive_level, crossed
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A setpoint beat is absorbed in the idle state and gives no result.
// A sample beat runs the bit-serial error-times-gain multiply (ST_GAIN), an update step
// (ST_UPDATE), the bit-serial drive-times-power multiply (ST_POWER) and a rounding
// step (ST_FINISH) that loads the result into the output register.
// Reset clears the sequencer, the loop state and the output valid flag.
// A result waits in the output register; a new input beat is taken meanwhile,
// and only the finish state of the next sample stalls until that result leaves.
module take_back_half_velocity_controller
  import tbh_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic                       func,
  input  wire logic signed [SPEED_W-1:0]  measured_velocity,
  input  wire logic signed [SPEED_W-1:0]  new_target,
  input  wire logic        [DRIVE_W-1:0]  drive_estimate,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic        [CMD_W-1:0]    motor_command,
  output      logic        [DRIVE_W-1:0]  drive_level,
  output      logic                       crossed,
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic        [INDEX_W-1:0]  cfg_index,
  input  wire logic        [GAIN_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [GAIN_W-1:0]  loop_gain;
  logic [POWER_W-1:0] max_power;

  // Loop state.
  logic signed [SPEED_W-1:0] target_speed;
  logic signed [SPEED_W-1:0] last_speed;
  logic signed [ERR_W-1:0]   previous_error;
  logic        [DRIVE_W-1:0] open_loop_estimate;
  logic        [DRIVE_W-1:0] drive_value;
  logic        [DRIVE_W-1:0] held_drive;
  logic                      first_crossing_pending;

  // Sequencer and serial datapath.
  state_t                    state;
  logic        [CNT_W-1:0]   count;
  logic signed [ERR_W-1:0]   error;
  logic        [PROD1_W-1:0] prod_gain;
  logic        [PROD2_W-1:0] prod_power;
  logic                      crossed_hold;

  // Combinational values.
  logic signed [ERR_W-1:0]   sample_error;
  logic signed [ERR_W-1:0]   setpoint_error;
  logic        [ERR_W-1:0]   error_mag;
  logic        [GAIN_W:0]    gain_sum;
  logic        [POWER_W:0]   power_sum;
  logic signed [PROD1_W:0]   prod_signed;
  logic signed [PROD1_W:0]   prod_rounded;
  logic signed [PROD1_W-8:0] drive_step;
  logic signed [PROD1_W-7:0] drive_sum;
  logic        [DRIVE_W-1:0] drive_clipped;
  logic                      sign_change;
  logic        [DRIVE_W-1:0] drive_next;
  logic        [PROD2_W:0]   cmd_sum;
  logic        [CMD_W+1:0]   cmd_full;
  logic        [CMD_W-1:0]   cmd_clipped;
  logic                      out_free;
  logic                      in_beat;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Errors against the stored target and the last speed.
  assign sample_error   = ERR_W'(target_speed) - ERR_W'(measured_velocity);
  assign setpoint_error = ERR_W'(new_target) - ERR_W'(last_speed);
  assign error_mag      = sample_error[ERR_W-1] ? ERR_W'(-sample_error)
                                                : ERR_W'(sample_error);

  // One add per cycle for each serial multiplier.
  assign gain_sum  = {1'b0, prod_gain[PROD1_W-1 -: GAIN_W]}
                   + (prod_gain[0] ? {1'b0, loop_gain} : '0);
  assign power_sum = {1'b0, prod_power[PROD2_W-1 -: POWER_W]}
                   + (prod_power[0] ? {1'b0, max_power} : '0);

  // Signed step rounded half up, then added to the drive and clipped.
  always_comb begin
    prod_signed  = error[ERR_W-1] ? -$signed({1'b0, prod_gain})
                                  : $signed({1'b0, prod_gain});
    prod_rounded = prod_signed + (PROD1_W+1)'(128);
    drive_step   = prod_rounded[PROD1_W:8];
    drive_sum    = $signed({6'b0, drive_value}) + (PROD1_W-6)'(drive_step);
    if (drive_sum[PROD1_W-7]) begin
      drive_clipped = '0;
    end else if (drive_sum > $signed({6'b0, DRIVE_ONE})) begin
      drive_clipped = DRIVE_ONE;
    end else begin
      drive_clipped = drive_sum[DRIVE_W-1:0];
    end
  end

  // Three-valued sign comparison of this error and the previous one.
  assign sign_change = (error[ERR_W-1] != previous_error[ERR_W-1])
                    || ((error == '0) != (previous_error == '0));

  // Take back half on a crossing; the first crossing after a setpoint loads the open-loop estimate.
  always_comb begin
    if (!sign_change) begin
      drive_next = drive_clipped;
    end else if (first_crossing_pending) begin
      drive_next = open_loop_estimate;
    end else begin
      drive_next = DRIVE_W'(({1'b0, drive_clipped} + {1'b0, held_drive}) >> 1);
    end
  end

  // Motor command rounding and limit.
  always_comb begin
    cmd_sum  = {1'b0, prod_power} + (PROD2_W+1)'(32768);
    cmd_full = cmd_sum[PROD2_W:16];
    if (cmd_full > {2'b0, CMD_LIMIT}) begin
      cmd_clipped = CMD_LIMIT;
    end else begin
      cmd_clipped = cmd_full[CMD_W-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_gain <= LOOP_GAIN_RESET;
      max_power <= MAX_POWER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOOP_GAIN: loop_gain <= cfg_data;
        CFG_MAX_POWER: max_power <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, loop state and serial multipliers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= ST_IDLE;
      count                  <= '0;
      target_speed           <= '0;
      last_speed             <= '0;
      previous_error         <= '0;
      open_loop_estimate     <= '0;
      drive_value            <= '0;
      held_drive             <= '0;
      first_crossing_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (func == FUNC_SETPOINT) begin
              target_speed           <= new_target;
              previous_error         <= setpoint_error;
              open_loop_estimate     <= (drive_estimate > DRIVE_ONE) ? DRIVE_ONE
                                                                     : drive_estimate;
              first_crossing_pending <= 1'b1;
              held_drive             <= '0;
            end else begin
              last_speed <= measured_velocity;
              error      <= sample_error;
              prod_gain  <= {GAIN_W'(0), error_mag[ERR_W-2:0]};
              count      <= CNT_W'(GAIN_MUL_CYCLES - 1);
              state      <= ST_GAIN;
            end
          end
        end
        ST_GAIN: begin
          prod_gain <= {gain_sum, prod_gain[ERR_W-2:1]};
          count     <= count - 1'b1;
          if (count == '0) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          drive_value    <= drive_next;
          previous_error <= error;
          crossed_hold   <= sign_change;
          if (sign_change) begin
            held_drive             <= drive_next;
            first_crossing_pending <= 1'b0;
          end
          prod_power <= {POWER_W'(0), drive_next};
          count      <= CNT_W'(POWER_MUL_CYCLES - 1);
          state      <= ST_POWER;
        end
        ST_POWER: begin
          prod_power <= {power_sum, prod_power[DRIVE_W-1:1]};
          count      <= count - 1'b1;
          if (count == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output valid flag: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register, loaded when a result leaves the sequencer.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      motor_command <= cmd_clipped;
      drive_level   <= drive_value;
      crossed       <= crossed_hold;
    end
  end

endmodule

`default_nettype wire
